/* design/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg
// shared constants and types for the block motion search
// ----------------------------------------------------------------------------
package bms_pkg;
  localparam int MaxBlockW = 32;
  localparam int MaxBlockH = 32;
  localparam int MaxSearch = 16;

  typedef enum logic [1:0] {
    OP_BLOCK  = 2'd0,
    OP_WINDOW = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] REG_FRAME_W = 3'd0;
  localparam logic [2:0] REG_FRAME_H = 3'd1;
  localparam logic [2:0] REG_BLOCK_W = 3'd2;
  localparam logic [2:0] REG_BLOCK_H = 3'd3;
  localparam logic [2:0] REG_SRCH_X  = 3'd4;
  localparam logic [2:0] REG_SRCH_Y  = 3'd5;

  localparam logic [31:0] NoCost = 32'hffffffff;
endpackage

/* design/bms_if.sv */
// ----------------------------------------------------------------------------
// bms_in_if / bms_out_if
// request and result channels of the block motion search
// ----------------------------------------------------------------------------
interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  pixel;
  logic [5:0]  store_row;
  logic [5:0]  store_col;
  logic [11:0] block_x;
  logic [11:0] block_y;
  modport source (output valid, op, pixel, store_row, store_col, block_x, block_y,
                  input ready);
  modport sink (input valid, op, pixel, store_row, store_col, block_x, block_y,
                output ready);
endinterface

interface bms_out_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] vec_x;
  logic signed [4:0] vec_y;
  logic [15:0]       mean_cost;
  logic              found;
  modport source (output valid, vec_x, vec_y, mean_cost, found, input ready);
  modport sink (input valid, vec_x, vec_y, mean_cost, found, output ready);
endinterface

/* design/bms_div.sv */
// ----------------------------------------------------------------------------
// bms_div
// restoring divider, one quotient bit per cycle, 32 by 13 bits
// ----------------------------------------------------------------------------
module bms_div import bms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [12:0] dsr;
  logic [32:0] trial;

  assign trial = {rem[31:0], quotient[31]} - {20'd0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 6'd32;
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem      <= trial[31:0];
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem      <= {rem[30:0], quotient[31]};
          quotient <= {quotient[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* design/block_motion_search_mse.sv */
// ----------------------------------------------------------------------------
// block_motion_search_mse
// full-search block matching by mean squared error over stored pixels
// ----------------------------------------------------------------------------
// channel  dir  fields
// inp      in   op pixel store_row store_col block_x block_y
// outp     out  vec_x vec_y mean_cost found
// cfg      in   cfg_we cfg_index cfg_data
//
// store requests are taken while idle and go straight into the memories
// a search is accepted, then for each offset it steps and clips the block,
// tests the overlap and moves on when skipped, or reads and accumulates the
// overlap pixels and divides when it qualifies; last the result is output
// the pace is set by the single read port of each store and the serial divider
// reset clears the control state and loads defaults into the config registers;
// stores are not cleared; a finished result holds in the output register until taken
// ----------------------------------------------------------------------------
module block_motion_search_mse import bms_pkg::*; #(
  parameter int MAX_BLOCK_W = MaxBlockW,
  parameter int MAX_BLOCK_H = MaxBlockH,
  parameter int MAX_SEARCH  = MaxSearch
) (
  input  logic        clk,
  input  logic        rst,
  bms_in_if.sink      inp,
  bms_out_if.source   outp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int WinW  = 2 * MAX_SEARCH + MAX_BLOCK_W;
  localparam int WinH  = 2 * MAX_SEARCH + MAX_BLOCK_H;
  localparam int BAw   = $clog2(MAX_BLOCK_W * MAX_BLOCK_H);
  localparam int WAw   = $clog2(WinW * WinH);

  // config registers
  logic [12:0] frame_w, frame_h;
  logic [5:0]  blk_w, blk_h;
  logic [4:0]  srch_x, srch_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= 13'd640;
      frame_h <= 13'd480;
      blk_w   <= 6'd16;
      blk_h   <= 6'd16;
      srch_x  <= 5'd8;
      srch_y  <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_W: frame_w <= cfg_data;
        REG_FRAME_H: frame_h <= cfg_data;
        REG_BLOCK_W: blk_w   <= cfg_data[5:0];
        REG_BLOCK_H: blk_h   <= cfg_data[5:0];
        REG_SRCH_X:  srch_x  <= cfg_data[4:0];
        REG_SRCH_Y:  srch_y  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [7:0] block_mem  [MAX_BLOCK_W*MAX_BLOCK_H];
  logic [7:0] window_mem [WinW*WinH];
  logic [7:0] blk_q, win_q;
  logic [BAw-1:0] blk_ra;
  logic [WAw-1:0] win_ra;

  typedef enum logic [2:0] {S_IDLE, S_OFF, S_CLIP, S_ACC, S_DIV, S_NEXT, S_OUT} state_t;
  state_t state;

  logic accept;
  assign inp.ready = (state == S_IDLE);
  assign accept = inp.valid && inp.ready;

  always_ff @(posedge clk) begin
    if (accept && inp.op == OP_BLOCK && 32'(inp.store_row) < MAX_BLOCK_H &&
        32'(inp.store_col) < MAX_BLOCK_W)
      block_mem[BAw'(32'(inp.store_row) * MAX_BLOCK_W + 32'(inp.store_col))] <= inp.pixel;
    if (accept && inp.op == OP_WINDOW && 32'(inp.store_row) < WinH &&
        32'(inp.store_col) < WinW)
      window_mem[WAw'(32'(inp.store_row) * WinW + 32'(inp.store_col))] <= inp.pixel;
    blk_q <= block_mem[blk_ra];
    win_q <= window_mem[win_ra];
  end

  // saturated sizes
  logic [6:0] bw, bh;
  logic [5:0] sx, sy;
  always_comb begin
    bw = (blk_w == 6'd0) ? 7'd1 : (32'(blk_w) > MAX_BLOCK_W) ? 7'(MAX_BLOCK_W) : {1'b0, blk_w};
    bh = (blk_h == 6'd0) ? 7'd1 : (32'(blk_h) > MAX_BLOCK_H) ? 7'(MAX_BLOCK_H) : {1'b0, blk_h};
    sx = (32'(srch_x) > MAX_SEARCH) ? 6'(MAX_SEARCH) : {1'b0, srch_x};
    sy = (32'(srch_y) > MAX_SEARCH) ? 6'(MAX_SEARCH) : {1'b0, srch_y};
  end

  // scan state
  logic [11:0] bx, by;
  logic signed [6:0] ox, oy;
  logic signed [14:0] px, py;
  logic [6:0] x0, x1, y0, y1, cx, cy;
  logic [13:0] matched;
  logic [31:0] sum, best;
  logic signed [6:0] best_x, best_y;
  logic pipe_v, pipe_v2;
  logic signed [17:0] diff;
  logic [15:0] sq;

  // clip helper
  function automatic logic [6:0] clip(input logic signed [14:0] v, input logic [6:0] hi);
    if (v < 0) return 7'd0;
    if (v > $signed({8'd0, hi})) return hi;
    return v[6:0];
  endfunction

  logic div_start, div_done;
  logic [31:0] quot;
  bms_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum),
    .divisor(matched[12:0]), .done(div_done), .quotient(quot)
  );

  logic signed [7:0] wr, wc;
  assign wr = 8'(oy) + 8'(sy) + 8'(cy);
  assign wc = 8'(ox) + 8'(sx) + 8'(cx);
  assign blk_ra = BAw'(32'(cy) * MAX_BLOCK_W + 32'(cx));
  assign win_ra = WAw'(32'(wr) * WinW + 32'(wc));
  assign diff = 18'($signed({1'b0, win_q}) - $signed({1'b0, blk_q}));
  assign div_start = (state == S_ACC) && !pipe_v && !pipe_v2 && (cy == y1);

  logic last_x, last_y;
  assign last_x = (ox == $signed(7'(sx)) - 7'sd1);
  assign last_y = (oy == $signed(7'(sy)) - 7'sd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      outp.valid <= 1'b0;
      pipe_v     <= 1'b0;
      pipe_v2    <= 1'b0;
    end else begin
      if (outp.valid && outp.ready && state != S_OUT) outp.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept && inp.op == OP_SEARCH) begin
          bx   <= inp.block_x;
          by   <= inp.block_y;
          ox   <= -$signed(7'(sx));
          oy   <= -$signed(7'(sy));
          best <= NoCost;
          best_x <= '0;
          best_y <= '0;
          state <= (sx == 6'd0 || sy == 6'd0) ? S_OUT : S_OFF;
        end
        S_OFF: begin
          px <= $signed({3'd0, bx}) + 15'(ox);
          py <= $signed({3'd0, by}) + 15'(oy);
          state <= S_CLIP;
        end
        S_CLIP: begin
          x0 <= clip(-px, bw);
          y0 <= clip(-py, bh);
          x1 <= clip($signed({2'd0, frame_w}) - px, bw);
          y1 <= clip($signed({2'd0, frame_h}) - py, bh);
          cx <= clip(-px, bw);
          cy <= clip(-py, bh);
          sum <= '0;
          pipe_v <= 1'b0;
          pipe_v2 <= 1'b0;
          matched <= {7'd0, clip($signed({2'd0, frame_h}) - py, bh) - clip(-py, bh)} *
                     {7'd0, clip($signed({2'd0, frame_w}) - px, bw) - clip(-px, bw)};
          state <= S_ACC;
        end
        S_ACC: begin
          // overlap test is made once matched is known
          if (matched == 14'd0 || y1 <= y0 || x1 <= x0 ||
              32'(matched) < (32'(bw) * 32'(bh)) / 2) begin
            state <= S_NEXT;
          end else begin
            pipe_v  <= (cy != y1);
            pipe_v2 <= pipe_v;
            if (pipe_v) sq <= 16'(diff * diff);
            if (pipe_v2) sum <= sum + 32'(sq);
            if (cy != y1) begin
              if (cx + 7'd1 == x1) begin
                cx <= x0;
                cy <= cy + 7'd1;
              end else cx <= cx + 7'd1;
            end
            if (div_start) state <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          if (quot < best) begin
            best   <= quot;
            best_x <= ox;
            best_y <= oy;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (last_x) begin
            ox <= -$signed(7'(sx));
            oy <= oy + 7'sd1;
          end else ox <= ox + 7'sd1;
          state <= (last_x && last_y) ? S_OUT : S_OFF;
        end
        S_OUT: if (!outp.valid || outp.ready) begin
          outp.valid     <= 1'b1;
          outp.vec_x     <= best_x[4:0];
          outp.vec_y     <= best_y[4:0];
          outp.found     <= (best != NoCost);
          outp.mean_cost <= (best == NoCost) ? 16'd0 : best[15:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
